/* rtl/core/frs_pkg.sv */
// Shared types and constants for the filtered rectangle insertion sorter.
// No dependencies; imported by frs_cell and filtered_rect_insertion_sort.
package frs_pkg;

    localparam int FIELD_W = 12;
    localparam int LIMIT_W = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd675;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // insert the broadcast rectangle in sorted place
        logic drain;  // shift every entry one cell toward the head
    } frs_ctrl_t;

endpackage

/* rtl/core/frs_cell.sv */
// One cell of the sorting chain: holds one rectangle and its valid bit.
// Depends on frs_pkg for the control struct.
module frs_cell
    import frs_pkg::*;
#(
    parameter int W = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  frs_ctrl_t      ctrl,
    input  logic [4*W-1:0] new_data,
    input  logic           prev_le,
    input  logic           prev_valid,
    input  logic [4*W-1:0] prev_data,
    input  logic           next_valid,
    input  logic [4*W-1:0] next_data,
    output logic           le,
    output logic           valid,
    output logic [4*W-1:0] data
);

    logic           valid_reg;
    logic           valid_next;
    logic [4*W-1:0] data_reg;
    logic [4*W-1:0] data_next;
    logic           keep;

    // Entry stays put when it is valid and not greater than the new key
    assign le   = valid_reg && (data_reg[4*W-1:3*W] <= new_data[4*W-1:3*W]);
    assign keep = le;

    // Choose between hold, take the new rectangle, shift right, shift left
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.drain)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
        else if (ctrl.load && !keep)
        begin
            if (prev_le)
            begin
                valid_next = 1'b1;
                data_next  = new_data;
            end
            else
            begin
                valid_next = prev_valid;
                data_next  = prev_data;
            end
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* rtl/core/filtered_rect_insertion_sort.sv */
// Latency: a rectangle is placed in the chain at the edge it is accepted.
// Throughput: one rectangle per cycle while loading; after the last rectangle
// the sorted run drains from the head cell one result per cycle while out_ready
// is high (one empty-set result if none kept); no input is taken in the drain.
// Reset: asynchronous, active low; chain empty, overflow clear, limit 675.
// Top level of the rectangle sorter; depends on frs_pkg and frs_cell.
module filtered_rect_insertion_sort
    import frs_pkg::*;
#(
    parameter int CAPACITY   = 32,
    parameter int COORD_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] rect_x,
    input  logic [FIELD_W-1:0] rect_y,
    input  logic [FIELD_W-1:0] rect_width,
    input  logic [FIELD_W-1:0] rect_height,
    input  logic               last_rect,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIELD_W-1:0] out_x,
    output logic [FIELD_W-1:0] out_y,
    output logic [FIELD_W-1:0] out_width,
    output logic [FIELD_W-1:0] out_height,
    output logic               end_of_set,
    output logic               set_empty,
    output logic               overflowed
);

    localparam int W  = COORD_BITS;
    localparam int KB = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;

    typedef enum logic [1:0] {S_LOAD, S_DRAIN, S_EMPTY} state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               ovf_reg;
    logic               ovf_next;
    frs_ctrl_t          ctrl;
    logic [4*W-1:0]     new_data;
    logic               in_fire;
    logic               out_fire;
    logic               pass;
    logic               full;

    logic [CAPACITY-1:0] le;
    logic [CAPACITY-1:0] valid;
    logic [4*W-1:0]      data [CAPACITY];

    // Mask incoming coordinates to the stored width
    assign new_data = {W'(rect_x[KB-1:0]), W'(rect_y[KB-1:0]),
                       W'(rect_width[KB-1:0]), W'(rect_height[KB-1:0])};

    assign in_ready = (state_reg == S_LOAD);
    assign out_valid = (state_reg != S_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign pass     = {1'b0, rect_width} < limit_reg;
    assign full     = valid[CAPACITY-1];

    assign ctrl.load  = in_fire && pass && !full;
    assign ctrl.drain = out_fire && (state_reg == S_DRAIN);

    // Build the chain of cells
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic           p_le;
            logic           p_valid;
            logic [4*W-1:0] p_data;
            logic           n_valid;
            logic [4*W-1:0] n_data;
            if (i == 0)
            begin : g_head
                assign p_le    = 1'b1;
                assign p_valid = 1'b1;
                assign p_data  = new_data;
            end
            else
            begin : g_body
                assign p_le    = le[i-1];
                assign p_valid = valid[i-1];
                assign p_data  = data[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_tail
                assign n_valid = 1'b0;
                assign n_data  = data[i];
            end
            else
            begin : g_inner
                assign n_valid = valid[i+1];
                assign n_data  = data[i+1];
            end
            frs_cell #(.W(W)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_data   (new_data),
                .prev_le    (p_le),
                .prev_valid (p_valid),
                .prev_data  (p_data),
                .next_valid (n_valid),
                .next_data  (n_data),
                .le         (le[i]),
                .valid      (valid[i]),
                .data       (data[i])
            );
        end
    endgenerate

    // Sequence load, drain and empty report
    always_comb
    begin
        state_next = state_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (pass && full)
                        ovf_next = 1'b1;
                    if (last_rect)
                        state_next = (valid[0] || ctrl.load) ? S_DRAIN : S_EMPTY;
                end
            end
            S_DRAIN, S_EMPTY:
            begin
                if (out_fire && end_of_set)
                begin
                    state_next = S_LOAD;
                    ovf_next   = 1'b0;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    // Hold state, overflow flag and width limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            ovf_reg   <= 1'b0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
        end
    end

    // Present the head cell, or zeros for an empty set
    assign set_empty  = (state_reg == S_EMPTY);
    assign end_of_set = set_empty || !valid[1];
    assign overflowed = ovf_reg;
    assign out_x      = set_empty ? '0 : FIELD_W'(data[0][3*W +: KB]);
    assign out_y      = set_empty ? '0 : FIELD_W'(data[0][2*W +: KB]);
    assign out_width  = set_empty ? '0 : FIELD_W'(data[0][W +: KB]);
    assign out_height = set_empty ? '0 : FIELD_W'(data[0][0 +: KB]);

endmodule

/* rtl/core/frs_checker.sv */
// Port-level assertions for the rectangle sorter, bound to the top level.
// Depends on frs_pkg for field widths and on filtered_rect_insertion_sort.
module frs_checker
    import frs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FIELD_W-1:0] out_x,
    input logic [FIELD_W-1:0] out_y,
    input logic [FIELD_W-1:0] out_width,
    input logic [FIELD_W-1:0] out_height,
    input logic               end_of_set,
    input logic               set_empty,
    input logic               overflowed
);

    // Input and output never open together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while results pending");

    // Empty report is a single zeroed end-of-set transaction
    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && set_empty) |->
        (end_of_set && out_x == '0 && out_y == '0 && out_width == '0 && out_height == '0))
        else $error("malformed empty-set transaction");

    // Overflow flag is steady across a run
    a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !end_of_set) |=> (out_valid && $stable(overflowed)))
        else $error("overflow flag changed inside a run");

    // Input reopens right after the end of a run
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && end_of_set) |=> (in_ready && !out_valid))
        else $error("input not reopened after run");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(end_of_set)))
        else $error("stalled result changed");

endmodule

bind filtered_rect_insertion_sort frs_checker u_frs_checker (.*);

/* sim/tb_filtered_rect_insertion_sort.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the filtered rectangle insertion sorter.
// Depends on frs_pkg and filtered_rect_insertion_sort; checks every sorted run
// against an in-bench predictor under directed, random and back-pressure traffic.
module tb_filtered_rect_insertion_sort;
    import frs_pkg::*;

    localparam int CAPACITY    = 32;
    localparam int CYCLE_LIMIT = 150000;
    localparam int SETTLE_GAP  = CAPACITY + 8;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] h;
    } rect_t;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] w;
        logic [FIELD_W-1:0] h;
        logic               last_of_set;
        logic               empty_set;
        logic               dropped;
    } rect_result_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [FIELD_W-1:0] rect_x = '0;
    logic [FIELD_W-1:0] rect_y = '0;
    logic [FIELD_W-1:0] rect_width = '0;
    logic [FIELD_W-1:0] rect_height = '0;
    logic last_rect = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [FIELD_W-1:0] out_x;
    logic [FIELD_W-1:0] out_y;
    logic [FIELD_W-1:0] out_width;
    logic [FIELD_W-1:0] out_height;
    logic end_of_set;
    logic set_empty;
    logic overflowed;

    // Predictor state: a private copy of the sorted store and the limit
    rect_t              sorted_copy [CAPACITY];
    int unsigned        kept_copy = 0;
    bit                 dropped_copy = 1'b0;
    logic [LIMIT_W-1:0] limit_copy = LIMIT_RESET;
    rect_result_t       expected_rects [$];
    rect_result_t       head_rect;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    bit hold_active = 1'b0;
    int hold_cycles = 0;

    int err_count = 0;
    int items_sent = 0;
    int sets_sent = 0;
    int results_checked = 0;
    int overflow_sets = 0;
    int empty_sets = 0;
    int cycle_count;

    filtered_rect_insertion_sort #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (FIELD_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .last_rect   (last_rect),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_width   (out_width),
        .out_height  (out_height),
        .end_of_set  (end_of_set),
        .set_empty   (set_empty),
        .overflowed  (overflowed)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Abort a hung run
    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // Hold the receiver off for a counted stretch when asked
    initial
    begin
        forever
        begin
            wait (hold_request);
            hold_active = 1'b1;
            repeat (hold_cycles) @(posedge clk);
            hold_active = 1'b0;
            hold_request = 1'b0;
        end
    end

    // Random receiver stalls
    always @(posedge clk)
        out_ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare each result transaction with the oldest expectation
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (expected_rects.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual x=%0d y=%0d w=%0d h=%0d",
                         $time, out_x, out_y, out_width, out_height);
            end
            else
            begin
                head_rect = expected_rects.pop_front();
                check_field("out_x", 32'(head_rect.x), 32'(out_x));
                check_field("out_y", 32'(head_rect.y), 32'(out_y));
                check_field("out_width", 32'(head_rect.w), 32'(out_width));
                check_field("out_height", 32'(head_rect.h), 32'(out_height));
                check_field("end_of_set", 32'(head_rect.last_of_set), 32'(end_of_set));
                check_field("set_empty", 32'(head_rect.empty_set), 32'(set_empty));
                check_field("overflowed", 32'(head_rect.dropped), 32'(overflowed));
            end
        end
    end

    // Filter and insert one rectangle; on the last one, queue the sorted run
    task automatic predict_sorted_run(input rect_t r, input bit last);
        int unsigned  pos;
        rect_result_t res;
        if ({1'b0, r.w} < limit_copy)
        begin
            if (kept_copy < CAPACITY)
            begin
                pos = kept_copy;
                while (pos > 0 && sorted_copy[pos-1].x > r.x)
                begin
                    sorted_copy[pos] = sorted_copy[pos-1];
                    pos--;
                end
                sorted_copy[pos] = r;
                kept_copy++;
            end
            else
                dropped_copy = 1'b1;
        end
        if (last)
        begin
            if (kept_copy == 0)
            begin
                res = '0;
                res.last_of_set = 1'b1;
                res.empty_set = 1'b1;
                res.dropped = dropped_copy;
                expected_rects.insert(expected_rects.size(), res);
                empty_sets++;
            end
            else
            begin
                for (int k = 0; k < kept_copy; k++)
                begin
                    res.x = sorted_copy[k].x;
                    res.y = sorted_copy[k].y;
                    res.w = sorted_copy[k].w;
                    res.h = sorted_copy[k].h;
                    res.last_of_set = (k + 1 == kept_copy);
                    res.empty_set = 1'b0;
                    res.dropped = dropped_copy;
                    expected_rects.insert(expected_rects.size(), res);
                end
            end
            if (dropped_copy)
                overflow_sets++;
            kept_copy = 0;
            dropped_copy = 1'b0;
        end
    endtask

    // Offer one rectangle after an optional idle gap and wait for its transaction
    task automatic send_rect(input rect_t r, input bit last);
        bit taken;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        rect_x <= r.x;
        rect_y <= r.y;
        rect_width <= r.w;
        rect_height <= r.h;
        last_rect <= last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        predict_sorted_run(r, last);
        items_sent++;
        if (last)
            sets_sent++;
    endtask

    function automatic rect_t make_rect(input int unsigned x, input int unsigned y,
                                        input int unsigned w, input int unsigned h);
        rect_t r;
        r.x = FIELD_W'(x);
        r.y = FIELD_W'(y);
        r.w = FIELD_W'(w);
        r.h = FIELD_W'(h);
        return r;
    endfunction

    // Random rectangle; widths lean toward the current limit
    function automatic rect_t random_rect(input bit narrow_x);
        rect_t       r;
        int unsigned top;
        top = (limit_copy > 4096) ? 4096 : 32'(limit_copy);
        r.x = narrow_x ? FIELD_W'($urandom_range(15)) : FIELD_W'($urandom_range(4095));
        r.y = FIELD_W'($urandom_range(4095));
        r.h = FIELD_W'($urandom_range(4095));
        case ($urandom_range(3))
            0: r.w = FIELD_W'($urandom_range(4095));
            1, 2: r.w = (top == 0) ? FIELD_W'($urandom_range(4095))
                                   : FIELD_W'($urandom_range(top - 1));
            default: r.w = (top > 4095) ? FIELD_W'(4095) : FIELD_W'(top);
        endcase
        return r;
    endfunction

    // Drop valid and wait until every queued result has drained
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_rects.size() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    task automatic write_limit(input int unsigned value);
        settle_block();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= LIMIT_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limit_copy = LIMIT_W'(value);
    endtask

    // Extremes, stable ordering, empty sets and a dropped last rectangle
    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_rect(make_rect(100, 0, 10, 4095), 1'b0);
        send_rect(make_rect(0, 4095, 674, 0), 1'b0);
        send_rect(make_rect(4095, 4095, 0, 4095), 1'b0);
        send_rect(make_rect(100, 1, 675, 1), 1'b0);
        send_rect(make_rect(100, 2, 4095, 2), 1'b0);
        send_rect(make_rect(100, 3, 1, 3), 1'b0);
        send_rect(make_rect(0, 5, 2, 5), 1'b0);
        send_rect(make_rect(4095, 6, 3, 6), 1'b0);
        send_rect(make_rect(50, 7, 674, 7), 1'b1);
        // nothing kept
        send_rect(make_rect(12'hAAA, 12'h555, 675, 12'hAAA), 1'b1);
        // neither rectangle survives the filter, so nothing is kept
        send_rect(make_rect(12, 12, 4095, 12), 1'b0);
        send_rect(make_rect(12'h555, 12'hAAA, 12'h2AA, 12'h555), 1'b1);
        // last rectangle discarded, earlier one kept
        send_rect(make_rect(7, 8, 5, 9), 1'b0);
        send_rect(make_rect(3, 4, 4095, 5), 1'b1);
        // descending keys insert at the head every time
        for (int i = 0; i < 6; i++)
            send_rect(make_rect(4000 - i * 700, i, i, i), i == 5);
        settle_block();
    endtask

    // Limit zero, one, the full range, above the range and back to reset
    task automatic test_width_limits();
        write_limit(0);
        send_rect(make_rect(0, 0, 0, 0), 1'b0);
        send_rect(make_rect(1, 1, 0, 1), 1'b1);
        write_limit(1);
        send_rect(make_rect(5, 5, 0, 5), 1'b0);
        send_rect(make_rect(6, 6, 1, 6), 1'b0);
        send_rect(make_rect(2, 2, 0, 2), 1'b1);
        write_limit(4095);
        send_rect(make_rect(9, 9, 4095, 9), 1'b0);
        send_rect(make_rect(8, 8, 4094, 8), 1'b1);
        write_limit(4096);
        send_rect(make_rect(9, 9, 4095, 9), 1'b1);
        write_limit(8191);
        send_rect(make_rect(4095, 4095, 4095, 4095), 1'b0);
        send_rect(make_rect(0, 0, 4095, 0), 1'b1);
        write_limit(LIMIT_RESET);
        settle_block();
    endtask

    // Exactly full store, then overflow, then a clean set after it
    task automatic test_store_overflow();
        write_limit(2000);
        send_idle_pct = 19;
        recv_stall_pct = 19;
        for (int i = 0; i < CAPACITY; i++)
            send_rect(make_rect($urandom_range(7), $urandom_range(4095), $urandom_range(1999),
                                $urandom_range(4095)), i == CAPACITY - 1);
        for (int i = 0; i < CAPACITY + 3; i++)
            send_rect(make_rect($urandom_range(4095), i, $urandom_range(1999), i),
                      i == CAPACITY + 2);
        send_rect(make_rect(77, 77, 77, 77), 1'b1);
        settle_block();
    endtask

    // Hold the receiver off while the sender keeps offering a second set
    task automatic test_receiver_hold_off();
        write_limit(4096);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
            send_rect(random_rect(i[0]), i == 39);
        for (int i = 0; i < 20; i++)
            send_rect(random_rect(1'b1), i == 19);
        settle_block();
    endtask

    // Random sets of mixed length under one idling profile
    task automatic run_random_sets(input int n_items, input int send_pct, input int recv_pct);
        int sent;
        int len;
        int pick;
        bit narrow;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(10, 1);
            else if (pick < 92)
                len = $urandom_range(31, 11);
            else
                len = $urandom_range(40, 32);
            narrow = $urandom_range(1);
            for (int i = 0; i < len; i++)
                send_rect(random_rect(narrow), i == len - 1);
            sent += len;
        end
    endtask

    task automatic test_random_sets();
        write_limit($urandom_range(4096, 1));
        run_random_sets(70, 0, 0);
        write_limit(LIMIT_RESET);
        run_random_sets(70, 46, 0);
        write_limit($urandom_range(8191));
        run_random_sets(70, 0, 46);
        write_limit($urandom_range(4095, 100));
        run_random_sets(70, 19, 19);
        settle_block();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_width_limits();
        test_store_overflow();
        test_receiver_hold_off();
        test_random_sets();

        if (expected_rects.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $time, expected_rects.size());
        end
        $display("Sorted %0d rectangles in %0d sets under several width limits and stall mixes;",
                 items_sent, sets_sent);
        $display("checked %0d results, %0d empty sets, %0d sets with dropped rectangles.",
                 results_checked, empty_sets, overflow_sets);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
